// ===== rtl/core/pcr_pkg.sv =====
// Shared types and constants for the pinch coordinate remap pipeline.
// Used by every module in rtl/core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pcr_pkg;

    // Largest frame dimension that is honored; larger settings act as this.
    localparam int MAX_DIM = 4096;
    // Default number of fraction bits in distance and scale.
    localparam int FRAC_BITS = 16;

    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int AMT_W   = 16;
    localparam int DATA_W  = 16;
    localparam int IDX_W   = 2;
    // Doubled signed offset from the centre.
    localparam int OFF_W   = 15;
    // Width of the squared doubled radius.
    localparam int R2_W    = 26;

    typedef enum logic [IDX_W-1:0] {
        REG_AMOUNT = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic signed [AMT_W-1:0] amount;
        logic [DIM_W-1:0]        width;
        logic [DIM_W-1:0]        height;
    } t_cfg;

    // Data that rides along with an item through the root stages.
    typedef struct packed {
        logic                    in_unit;
        logic signed [OFF_W-1:0] x2;
        logic signed [OFF_W-1:0] y2;
    } t_side;

endpackage

`default_nettype wire

// ===== rtl/core/pinch_coordinate_remap.sv =====
// Pinch distortion coordinate remap: destination pixel in, source pixel out.
// Top level; depends on pcr_pkg, pcr_cfg, pcr_div and pcr_sqrt.
//
// Usage: the input channel (i_valid, o_stall, i_dest_x, i_dest_y) carries
// one destination coordinate per transfer; the output channel (o_valid,
// i_stall, o_src_x, o_src_y) returns one source coordinate per transfer,
// in order. Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data
// (0 amount, 1 frame width, 2 frame height) while the pipeline is empty.
// The pipeline has three front stages, 2*FRAC_BITS divider stages,
// FRAC_BITS square root stages and seven stages for scale and mapping.
// Throughput is one transfer per cycle while the receiver does not stall.
// When the receiver stalls a valid result, the whole pipeline holds and
// o_stall is raised, so nothing is lost or repeated. Reset is synchronous;
// it empties the pipeline and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module pinch_coordinate_remap #(
    parameter int FRAC_BITS = pcr_pkg::FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [pcr_pkg::COORD_W-1:0]   i_dest_x,
    input  wire logic [pcr_pkg::COORD_W-1:0]   i_dest_y,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [pcr_pkg::COORD_W-1:0]        o_src_x,
    output logic [pcr_pkg::COORD_W-1:0]        o_src_y,
    input  wire logic                          i_cfg_we,
    input  wire logic [pcr_pkg::IDX_W-1:0]     i_cfg_idx,
    input  wire logic [pcr_pkg::DATA_W-1:0]    i_cfg_data
);

    localparam int F    = FRAC_BITS;
    localparam int OW   = pcr_pkg::OFF_W;
    localparam int DW   = pcr_pkg::DIM_W;
    localparam int RW   = pcr_pkg::R2_W;
    localparam int PW   = F + pcr_pkg::AMT_W + 2;
    localparam int SW   = F + 3;
    localparam int MW   = OW + SW;
    localparam int NW   = MW + 1;
    localparam int QW   = NW - F - 1;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    pcr_pkg::t_cfg w_cfg;
    logic          w_adv;

    pcr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    // The squared radius only changes with configuration.
    logic [DW-1:0] w_r;
    logic [RW-1:0] r_r2;
    assign w_r = (w_cfg.width > w_cfg.height) ? w_cfg.width : w_cfg.height;
    always_ff @(posedge i_clk) begin
        r_r2 <= RW'(w_r * w_r);
    end

    // Front: doubled offsets, squares, distance test.
    logic                 r_f0_valid, r_f1_valid, r_f2_valid;
    logic signed [OW-1:0] r_f0_x2, r_f0_y2, r_f1_x2, r_f1_y2;
    logic [RW-1:0]        r_f1_sx, r_f1_sy, r_f2_rem;
    pcr_pkg::t_side       r_f2_side;
    logic [RW:0]          w_sum;
    logic                 w_in_unit;

    assign w_sum     = {1'b0, r_f1_sx} + {1'b0, r_f1_sy};
    assign w_in_unit = (w_sum < {1'b0, r_r2});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_valid <= 1'b0;
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else if (w_adv) begin
            r_f0_valid <= i_valid;
            r_f1_valid <= r_f0_valid;
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f0_x2 <= $signed({2'b00, i_dest_x, 1'b0}) - $signed({2'b00, w_cfg.width});
            r_f0_y2 <= $signed({2'b00, i_dest_y, 1'b0}) - $signed({2'b00, w_cfg.height});
            r_f1_x2 <= r_f0_x2;
            r_f1_y2 <= r_f0_y2;
            r_f1_sx <= RW'(r_f0_x2 * r_f0_x2);
            r_f1_sy <= RW'(r_f0_y2 * r_f0_y2);
            r_f2_rem <= w_in_unit ? w_sum[RW-1:0] : '0;
            r_f2_side.in_unit <= w_in_unit;
            r_f2_side.x2      <= r_f1_x2;
            r_f2_side.y2      <= r_f1_y2;
        end
    end

    logic             w_dv_valid, w_sq_valid;
    logic [2*F-1:0]   w_quo;
    logic [F-1:0]     w_root;
    pcr_pkg::t_side   w_dv_side, w_sq_side;

    pcr_div #(.FRAC_BITS(F)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_f2_valid),
        .i_rem   (r_f2_rem),
        .i_r2    (r_r2),
        .i_side  (r_f2_side),
        .o_valid (w_dv_valid),
        .o_quo   (w_quo),
        .o_side  (w_dv_side)
    );

    pcr_sqrt #(.FRAC_BITS(F)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_dv_valid),
        .i_rad   (w_quo),
        .i_side  (w_dv_side),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // Back: scale and mapping, seven stages.
    logic [6:0]           r_bv;
    pcr_pkg::t_side       r_bs [0:3];
    logic [F:0]           r_e, r_e2;
    logic signed [PW-1:0] r_prod;
    logic signed [SW-1:0] r_scale;
    logic signed [MW-1:0] r_mx, r_my;
    logic signed [NW-1:0] r_nx, r_ny;
    logic [2*F+1:0]       w_ee;
    logic signed [SW-1:0] w_term;

    assign w_ee   = r_e * r_e;
    assign w_term = r_prod[PW-1:15];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (w_adv) begin
            r_bv <= {r_bv[5:0], w_sq_valid};
        end
    end

    function automatic logic [pcr_pkg::COORD_W-1:0] clamp_axis(
        input logic signed [NW-1:0] num,
        input logic [DW-1:0]        dim
    );
        logic [QW-1:0] q;
        logic [QW-1:0] lim;
        q   = num[NW-1:F+1];
        lim = QW'(dim - DW'(1));
        if (num < 0) begin
            q = '0;
        end else if (q > lim) begin
            q = lim;
        end
        return q[pcr_pkg::COORD_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_bs[0] <= w_sq_side;
            for (int k = 1; k < 4; k++) begin
                r_bs[k] <= r_bs[k-1];
            end
            r_e     <= ONE - {1'b0, w_root};
            r_e2    <= w_ee[2*F:F];
            r_prod  <= PW'(w_cfg.amount * $signed({1'b0, r_e2}));
            r_scale <= r_bs[2].in_unit ? ($signed(SW'(ONE)) - w_term) : $signed(SW'(ONE));
            r_mx    <= r_bs[3].x2 * r_scale;
            r_my    <= r_bs[3].y2 * r_scale;
            r_nx    <= $signed({{(NW-DW-F){1'b0}}, w_cfg.width, {F{1'b0}}}) + NW'(r_mx);
            r_ny    <= $signed({{(NW-DW-F){1'b0}}, w_cfg.height, {F{1'b0}}}) + NW'(r_my);
            o_src_x <= clamp_axis(r_nx, w_cfg.width);
            o_src_y <= clamp_axis(r_ny, w_cfg.height);
        end
    end

    assign o_valid = r_bv[6];

    a_src_x_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (DW'(o_src_x) < w_cfg.width))
        else $error("source column outside frame");

    a_src_y_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (DW'(o_src_y) < w_cfg.height))
        else $error("source row outside frame");

    a_front_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(r_f0_valid) && $stable(r_bv)))
        else $error("pipeline moved during output stall");

endmodule

`default_nettype wire

// ===== rtl/core/pcr_cfg.sv =====
// Configuration registers with the effective frame dimensions.
// Depends on pcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcr_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [pcr_pkg::IDX_W-1:0]   i_cfg_idx,
    input  wire logic [pcr_pkg::DATA_W-1:0]  i_cfg_data,
    output pcr_pkg::t_cfg                    o_cfg
);

    logic signed [pcr_pkg::AMT_W-1:0] r_amount;
    logic [pcr_pkg::DIM_W-1:0]        r_width;
    logic [pcr_pkg::DIM_W-1:0]        r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amount <= pcr_pkg::AMT_W'(16384);
            r_width  <= pcr_pkg::DIM_W'(640);
            r_height <= pcr_pkg::DIM_W'(480);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcr_pkg::REG_AMOUNT: begin
                    r_amount <= i_cfg_data;
                end
                pcr_pkg::REG_WIDTH: begin
                    r_width <= i_cfg_data[pcr_pkg::DIM_W-1:0];
                end
                pcr_pkg::REG_HEIGHT: begin
                    r_height <= i_cfg_data[pcr_pkg::DIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // A zero dimension acts as one, an oversized one as the maximum.
    function automatic logic [pcr_pkg::DIM_W-1:0] eff_dim(input logic [pcr_pkg::DIM_W-1:0] v);
        logic [pcr_pkg::DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = pcr_pkg::DIM_W'(1);
        end else if (32'(v) > pcr_pkg::MAX_DIM) begin
            res = pcr_pkg::DIM_W'(pcr_pkg::MAX_DIM);
        end
        return res;
    endfunction

    always_comb begin
        o_cfg.amount = r_amount;
        o_cfg.width  = eff_dim(r_width);
        o_cfg.height = eff_dim(r_height);
    end

endmodule

`default_nettype wire

// ===== rtl/core/pcr_div.sv =====
// Restoring divider pipeline, one quotient bit per stage: S * 2^(2F) / R^2.
// Depends on pcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcr_div #(
    parameter int FRAC_BITS = pcr_pkg::FRAC_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic                        i_valid,
    input  wire logic [pcr_pkg::R2_W-1:0]    i_rem,
    input  wire logic [pcr_pkg::R2_W-1:0]    i_r2,
    input  pcr_pkg::t_side                   i_side,
    output logic                             o_valid,
    output logic [2*FRAC_BITS-1:0]           o_quo,
    output pcr_pkg::t_side                   o_side
);

    localparam int N  = 2 * FRAC_BITS;
    localparam int RW = pcr_pkg::R2_W;

    logic                 w_valid [0:N-1];
    logic [RW-1:0]        w_rem   [0:N-1];
    logic [N-1:0]         w_quo   [0:N-1];
    pcr_pkg::t_side       w_side  [0:N-1];
    logic                 r_valid [0:N-1];
    logic [RW-1:0]        r_rem   [0:N-1];
    logic [N-1:0]         r_quo   [0:N-1];
    pcr_pkg::t_side       r_side  [0:N-1];

    assign w_valid[0] = i_valid;
    assign w_rem[0]   = i_rem;
    assign w_quo[0]   = '0;
    assign w_side[0]  = i_side;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [RW:0]   n_trial;
        logic          n_ge;
        logic [RW-1:0] n_rem;

        if (k > 0) begin : g_link
            assign w_valid[k] = r_valid[k-1];
            assign w_rem[k]   = r_rem[k-1];
            assign w_quo[k]   = r_quo[k-1];
            assign w_side[k]  = r_side[k-1];
        end

        always_comb begin
            n_trial = {w_rem[k], 1'b0};
            n_ge    = (n_trial >= {1'b0, i_r2});
            n_rem   = n_ge ? RW'(n_trial - {1'b0, i_r2}) : n_trial[RW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_adv) begin
                r_valid[k] <= w_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k]  <= n_rem;
                r_quo[k]  <= {w_quo[k][N-2:0], n_ge};
                r_side[k] <= w_side[k];
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_quo   = r_quo[N-1];
    assign o_side  = r_side[N-1];

endmodule

`default_nettype wire

// ===== rtl/core/pcr_sqrt.sv =====
// Integer square root pipeline, one root bit per stage (two radicand bits).
// Depends on pcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcr_sqrt #(
    parameter int FRAC_BITS = pcr_pkg::FRAC_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic                        i_valid,
    input  wire logic [2*FRAC_BITS-1:0]      i_rad,
    input  pcr_pkg::t_side                   i_side,
    output logic                             o_valid,
    output logic [FRAC_BITS-1:0]             o_root,
    output pcr_pkg::t_side                   o_side
);

    localparam int N  = FRAC_BITS;
    localparam int RW = FRAC_BITS + 2;

    logic                 w_valid [0:N-1];
    logic [2*N-1:0]       w_rad   [0:N-1];
    logic [RW-1:0]        w_rem   [0:N-1];
    logic [N-1:0]         w_root  [0:N-1];
    pcr_pkg::t_side       w_side  [0:N-1];
    logic                 r_valid [0:N-1];
    logic [2*N-1:0]       r_rad   [0:N-1];
    logic [RW-1:0]        r_rem   [0:N-1];
    logic [N-1:0]         r_root  [0:N-1];
    pcr_pkg::t_side       r_side  [0:N-1];

    assign w_valid[0] = i_valid;
    assign w_rad[0]   = i_rad;
    assign w_rem[0]   = '0;
    assign w_root[0]  = '0;
    assign w_side[0]  = i_side;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [RW+1:0] n_sh;
        logic [RW+1:0] n_trial;
        logic          n_ge;

        if (k > 0) begin : g_link
            assign w_valid[k] = r_valid[k-1];
            assign w_rad[k]   = r_rad[k-1];
            assign w_rem[k]   = r_rem[k-1];
            assign w_root[k]  = r_root[k-1];
            assign w_side[k]  = r_side[k-1];
        end

        // Stage k brings down the radicand bit pair counted from the top.
        always_comb begin
            n_sh    = {w_rem[k], w_rad[k][2*(N-1-k)+1 -: 2]};
            n_trial = (RW+2)'({w_root[k], 2'b01});
            n_ge    = (n_sh >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_adv) begin
                r_valid[k] <= w_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rad[k]  <= w_rad[k];
                r_rem[k]  <= n_ge ? RW'(n_sh - n_trial) : RW'(n_sh);
                r_root[k] <= {w_root[k][N-2:0], n_ge};
                r_side[k] <= w_side[k];
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule

`default_nettype wire
